// ===== design/fenced_ring_staging_allocator_top_defines.svh =====
// Assertion macros for the fenced ring staging allocator.
// Included by the checker; needs no other file.
`ifndef FENCED_RING_STAGING_ALLOCATOR_TOP_DEFINES_SVH
`define FENCED_RING_STAGING_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FSRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsra: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define FSRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsra: next-cycle check failed");

`endif

// ===== design/fsra_pkg.sv =====
// Shared types and constants for the fenced ring staging allocator.
// No dependencies; every design module uses it by scoped names.
`default_nettype none

package fsra_pkg;

	localparam int unsigned BLOCK_BYTES = 4096;
	localparam int unsigned BLOCK_SHIFT = 12;
	localparam int unsigned CAP_W       = 20;
	localparam int unsigned POS_W       = 32;
	localparam int unsigned FENCE_W     = 64;

	localparam logic [CAP_W-1:0] CAP_RESET  = 20'd4096;
	localparam logic [POS_W-1:0] RING_LIMIT = 32'h8000_0000;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_WAITED    = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RET_RD,
		S_RET_CMP,
		S_SPACE,
		S_FIT,
		S_CHK_LO,
		S_CHK_HI,
		S_FL_PUSH,
		S_FL_RD,
		S_FL_OUT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic               action;
		logic [POS_W-1:0]   byte_size;
		logic [FENCE_W-1:0] completed_fence;
		logic [FENCE_W-1:0] issued_fence;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   offset;
		logic [FENCE_W-1:0] wait_fence;
		logic [FENCE_W-1:0] flush_fence;
	} result_t;

	// ring size in bytes, saturated at 2^31
	function automatic logic [POS_W-1:0] ring_bytes(input logic [CAP_W-1:0] blocks);
		logic [CAP_W+BLOCK_SHIFT-1:0] prod;
		prod = {blocks, {BLOCK_SHIFT{1'b0}}};
		if (prod > (CAP_W+BLOCK_SHIFT)'(RING_LIMIT)) begin
			return RING_LIMIT;
		end
		return prod[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/fsra_seg_mem.sv =====
// Segment store: start offset and fence per queued segment.
// One write port, one registered read port. Uses fsra_pkg.
`default_nettype none

module fsra_seg_mem #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [$clog2(DEPTH)-1:0]          waddr,
	input  wire logic [fsra_pkg::POS_W-1:0]        wstart,
	input  wire logic [fsra_pkg::FENCE_W-1:0]      wfence,
	input  wire logic [$clog2(DEPTH)-1:0]          raddr,
	output logic      [fsra_pkg::POS_W-1:0]        rstart,
	output logic      [fsra_pkg::FENCE_W-1:0]      rfence
);

	logic [fsra_pkg::POS_W-1:0]   start_mem [DEPTH];
	logic [fsra_pkg::FENCE_W-1:0] fence_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			fence_mem[waddr] <= wfence;
		end
		rstart <= start_mem[raddr];
		rfence <= fence_mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/fsra_cmp.sv =====
// Shared unsigned less-or-equal unit, reused by every compare step.
// Uses fsra_pkg for the operand width.
`default_nettype none

module fsra_cmp (
	input  wire logic [fsra_pkg::FENCE_W-1:0] a,
	input  wire logic [fsra_pkg::FENCE_W-1:0] b,
	output logic                              le
);

	assign le = (a <= b);

endmodule

`default_nettype wire

// ===== design/fsra_ctrl.sv =====
// Sequencer and state of the allocator: ring position, batch, segment queue.
// Drives the shared compare unit and the segment store. Uses fsra_pkg.
`default_nettype none

module fsra_ctrl #(
	parameter int unsigned MAX_SEGMENTS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire fsra_pkg::item_t                      item,
	input  wire logic [fsra_pkg::POS_W-1:0]           cap_bytes,
	output logic                                      busy,
	output logic                                      done,
	output fsra_pkg::result_t                         result,
	output logic                                      mem_we,
	output logic [$clog2(MAX_SEGMENTS)-1:0]           mem_waddr,
	output logic [fsra_pkg::POS_W-1:0]                mem_wstart,
	output logic [fsra_pkg::FENCE_W-1:0]              mem_wfence,
	output logic [$clog2(MAX_SEGMENTS)-1:0]           mem_raddr,
	input  wire logic [fsra_pkg::POS_W-1:0]           mem_rstart,
	input  wire logic [fsra_pkg::FENCE_W-1:0]         mem_rfence,
	output logic [fsra_pkg::FENCE_W-1:0]              cmp_a,
	output logic [fsra_pkg::FENCE_W-1:0]              cmp_b,
	input  wire logic                                 cmp_le
);

	localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
	localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned SUM_W = CNT_W + 1;
	localparam int unsigned POS_W = fsra_pkg::POS_W;
	localparam int unsigned FW    = fsra_pkg::FENCE_W;

	localparam logic [SUM_W-1:0] MAX_SUM  = SUM_W'(MAX_SEGMENTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SEGMENTS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SEGMENTS);
	localparam logic [POS_W:0]   BLK_MASK = (POS_W+1)'(fsra_pkg::BLOCK_BYTES - 1);

	fsra_pkg::state_t state_q, state_nxt;

	logic [POS_W-1:0] wp_q;
	logic [POS_W-1:0] bb_q;
	logic             open_q;
	logic             fneed_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic             attempt_q;
	logic             wait_q;

	fsra_pkg::item_t   req_q;
	fsra_pkg::result_t res_q;
	logic [POS_W:0]    aligned_q;
	logic [FW-1:0]     limit_q;
	logic [POS_W-1:0]  space_q;
	logic [POS_W+1:0]  end_q;

	logic [POS_W:0]    aligned_in;
	logic [POS_W:0]    space_diff;
	logic [SUM_W-1:0]  tail_sum;
	logic [SUM_W-1:0]  last_sum;
	logic [IDX_W-1:0]  push_idx;
	logic [IDX_W-1:0]  last_idx;
	logic              queue_nz;
	logic              place;
	logic              pop;

	assign aligned_in = ({1'b0, item.byte_size} + BLK_MASK) & ~BLK_MASK;
	assign space_diff = {1'b0, cap_bytes} - {1'b0, wp_q};

	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign last_sum = tail_sum - SUM_W'(1);
	assign push_idx = (tail_sum >= MAX_SUM) ? IDX_W'(tail_sum - MAX_SUM) : IDX_W'(tail_sum);
	assign last_idx = (last_sum >= MAX_SUM) ? IDX_W'(last_sum - MAX_SUM) : IDX_W'(last_sum);

	assign queue_nz = (count_q != '0);
	assign pop      = (state_q == fsra_pkg::S_RET_CMP) && queue_nz && cmp_le;
	assign place    = ((state_q == fsra_pkg::S_FIT) && cmp_le && !queue_nz) ||
	                  ((state_q == fsra_pkg::S_CHK_LO) && !cmp_le) ||
	                  (state_q == fsra_pkg::S_CHK_HI);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fsra_pkg::S_IDLE: begin
				if (start) begin
					if (item.action == fsra_pkg::ACT_FLUSH) begin
						if (fneed_q) begin
							state_nxt = fsra_pkg::S_FL_PUSH;
						end else if (queue_nz) begin
							state_nxt = fsra_pkg::S_FL_RD;
						end else begin
							state_nxt = fsra_pkg::S_FINISH;
						end
					end else begin
						state_nxt = fsra_pkg::S_RET_RD;
					end
				end
			end
			fsra_pkg::S_RET_RD: state_nxt = fsra_pkg::S_RET_CMP;
			fsra_pkg::S_RET_CMP: begin
				if (queue_nz && cmp_le) begin
					state_nxt = fsra_pkg::S_RET_RD;
				end else if (wait_q) begin
					state_nxt = fsra_pkg::S_FINISH;
				end else begin
					state_nxt = fsra_pkg::S_SPACE;
				end
			end
			fsra_pkg::S_SPACE: state_nxt = fsra_pkg::S_FIT;
			fsra_pkg::S_FIT: begin
				if (cmp_le) begin
					state_nxt = queue_nz ? fsra_pkg::S_CHK_LO : fsra_pkg::S_FINISH;
				end else begin
					state_nxt = attempt_q ? fsra_pkg::S_FINISH : fsra_pkg::S_SPACE;
				end
			end
			fsra_pkg::S_CHK_LO: state_nxt = cmp_le ? fsra_pkg::S_CHK_HI : fsra_pkg::S_FINISH;
			// end of span at or below the segment start: no overlap
			fsra_pkg::S_CHK_HI: state_nxt = cmp_le ? fsra_pkg::S_FINISH : fsra_pkg::S_RET_RD;
			fsra_pkg::S_FL_PUSH: state_nxt = fsra_pkg::S_FINISH;
			fsra_pkg::S_FL_RD:   state_nxt = fsra_pkg::S_FL_OUT;
			fsra_pkg::S_FL_OUT:  state_nxt = fsra_pkg::S_FINISH;
			fsra_pkg::S_FINISH:  state_nxt = fsra_pkg::S_IDLE;
			default:             state_nxt = fsra_pkg::S_IDLE;
		endcase
	end

	// outputs and shared-unit operands
	always_comb begin
		busy       = (state_q != fsra_pkg::S_IDLE);
		done       = (state_q == fsra_pkg::S_FINISH);
		result     = res_q;
		mem_we     = (state_q == fsra_pkg::S_FL_PUSH) && (count_q != FULL_CNT);
		mem_waddr  = push_idx;
		mem_wstart = bb_q;
		mem_wfence = req_q.issued_fence;
		mem_raddr  = (state_q == fsra_pkg::S_FL_RD) ? last_idx : head_q;
		cmp_a      = '0;
		cmp_b      = '0;
		unique case (state_q)
			fsra_pkg::S_RET_CMP: begin
				cmp_a = mem_rfence;
				cmp_b = limit_q;
			end
			fsra_pkg::S_FIT: begin
				cmp_a = FW'(aligned_q);
				cmp_b = FW'(space_q);
			end
			fsra_pkg::S_CHK_LO: begin
				cmp_a = FW'(wp_q);
				cmp_b = FW'(mem_rstart);
			end
			fsra_pkg::S_CHK_HI: begin
				cmp_a = FW'(end_q);
				cmp_b = FW'(mem_rstart);
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fsra_pkg::S_IDLE;
			wp_q      <= '0;
			bb_q      <= '0;
			open_q    <= 1'b0;
			fneed_q   <= 1'b0;
			head_q    <= '0;
			count_q   <= '0;
			attempt_q <= 1'b0;
			wait_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == fsra_pkg::S_IDLE && start) begin
				attempt_q <= 1'b0;
				wait_q    <= 1'b0;
				if (item.action == fsra_pkg::ACT_ALLOC && !open_q) begin
					open_q <= 1'b1;
					bb_q   <= wp_q;
				end
			end
			if (pop) begin
				head_q  <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
				count_q <= count_q - CNT_W'(1);
			end
			// wrap once to the ring start
			if (state_q == fsra_pkg::S_FIT && !cmp_le && !attempt_q) begin
				wp_q      <= '0;
				bb_q      <= '0;
				attempt_q <= 1'b1;
			end
			if (place) begin
				wp_q    <= wp_q + aligned_q[POS_W-1:0];
				fneed_q <= 1'b1;
			end
			if (state_q == fsra_pkg::S_CHK_HI && !cmp_le) begin
				wait_q <= 1'b1;
			end
			if (state_q == fsra_pkg::S_FL_PUSH) begin
				open_q  <= 1'b0;
				fneed_q <= 1'b0;
				if (count_q != FULL_CNT) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (state_q == fsra_pkg::S_IDLE && start) begin
			req_q     <= item;
			aligned_q <= aligned_in;
			limit_q   <= item.completed_fence;
			res_q     <= '0;
		end
		if (state_q == fsra_pkg::S_SPACE) begin
			space_q <= space_diff[POS_W] ? '0 : space_diff[POS_W-1:0];
			end_q   <= {2'b00, wp_q} + {1'b0, aligned_q};
		end
		if (state_q == fsra_pkg::S_FIT && !cmp_le && attempt_q) begin
			res_q.status <= fsra_pkg::ST_EXHAUSTED;
			res_q.offset <= '0;
		end
		if (place) begin
			res_q.offset <= wp_q;
		end
		if (state_q == fsra_pkg::S_CHK_HI && !cmp_le) begin
			res_q.status     <= fsra_pkg::ST_WAITED;
			res_q.wait_fence <= mem_rfence;
			limit_q          <= mem_rfence;
		end
		if (state_q == fsra_pkg::S_FL_PUSH) begin
			res_q.flush_fence <= req_q.issued_fence;
			if (count_q == FULL_CNT) begin
				res_q.status <= fsra_pkg::ST_OVERFLOW;
			end
		end
		if (state_q == fsra_pkg::S_FL_OUT) begin
			res_q.flush_fence <= mem_rfence;
		end
	end

endmodule

`default_nettype wire

// ===== design/fenced_ring_staging_allocator_top.sv =====
// Top level of the fenced ring staging allocator: ring size register,
// sequencer, shared compare unit and segment store. Uses fsra_pkg.
//
//   port group            dir  handshake           payload
//   start / busy          in   start & !busy       item     (fsra_pkg::item_t)
//   done                  out  one-cycle strobe    result   (fsra_pkg::result_t)
//   cfg_we                in   write on cfg_we     cfg_wdata (capacity_blocks)
//
// An allocate beat reads and compares the oldest segment, retiring each one
// whose fence is complete, then runs the space and fit steps, again after a
// ring wrap, then the low and high overlap checks when segments remain queued;
// an overlap retires segments up to its fence. The compare unit and the one-read
// segment store set these steps. A flush pushes the batch or reads the newest one.
// Reset clears the sequencer, ring position and queue pointers; the segment
// store is not cleared and needs no clearing pass. busy is high from the cycle
// after acceptance until the result strobe; done cannot be held off.
`default_nettype none

module fenced_ring_staging_allocator_top #(
	parameter int unsigned MAX_SEGMENTS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire fsra_pkg::item_t                item,
	output logic                                busy,
	output logic                                done,
	output fsra_pkg::result_t                   result,
	input  wire logic                           cfg_we,
	input  wire logic [fsra_pkg::CAP_W-1:0]     cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);

	logic [fsra_pkg::POS_W-1:0]   cap_q;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic [IDX_W-1:0]             mem_raddr;
	logic [fsra_pkg::POS_W-1:0]   mem_wstart;
	logic [fsra_pkg::POS_W-1:0]   mem_rstart;
	logic [fsra_pkg::FENCE_W-1:0] mem_wfence;
	logic [fsra_pkg::FENCE_W-1:0] mem_rfence;
	logic [fsra_pkg::FENCE_W-1:0] cmp_a;
	logic [fsra_pkg::FENCE_W-1:0] cmp_b;
	logic                         cmp_le;

	// hold the ring size in bytes, saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= fsra_pkg::ring_bytes(fsra_pkg::CAP_RESET);
		end else if (cfg_we) begin
			cap_q <= fsra_pkg::ring_bytes(cfg_wdata);
		end
	end

	fsra_ctrl #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.cap_bytes  (cap_q),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wstart (mem_wstart),
		.mem_wfence (mem_wfence),
		.mem_raddr  (mem_raddr),
		.mem_rstart (mem_rstart),
		.mem_rfence (mem_rfence),
		.cmp_a      (cmp_a),
		.cmp_b      (cmp_b),
		.cmp_le     (cmp_le)
	);

	fsra_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.le (cmp_le)
	);

	fsra_seg_mem #(
		.DEPTH(MAX_SEGMENTS)
	) u_seg_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wstart (mem_wstart),
		.wfence (mem_wfence),
		.raddr  (mem_raddr),
		.rstart (mem_rstart),
		.rfence (mem_rfence)
	);

endmodule

`default_nettype wire

// ===== design/fsra_checker.sv =====
// Port-level checks for the allocator top level, attached by bind.
// Uses fsra_pkg and fenced_ring_staging_allocator_top_defines.svh.
`default_nettype none

`include "fenced_ring_staging_allocator_top_defines.svh"

module fsra_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire fsra_pkg::result_t result
);

	// an accepted beat keeps the block busy in the next cycle
	`FSRA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, start && !busy, busy)

	// the result strobe lasts exactly one cycle
	`FSRA_ASSERT_NXT(a_done_single, clk, arst_n, done, !done)

	// an exhausted allocation carries no offset and no fences
	`FSRA_ASSERT_IMP(a_exhausted_clean, clk, arst_n, done && (result.status == fsra_pkg::ST_EXHAUSTED), (result.offset == '0) && (result.wait_fence == '0) && (result.flush_fence == '0))

	// a wait only comes from an allocation, which returns no flush fence
	`FSRA_ASSERT_IMP(a_waited_no_flush, clk, arst_n, done && (result.status == fsra_pkg::ST_WAITED), result.flush_fence == '0)

endmodule

bind fenced_ring_staging_allocator_top fsra_checker u_fsra_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

// ===== tb/sv/tb_fenced_ring_staging_allocator_top.sv =====
// Self-checking bench for fenced_ring_staging_allocator_top: a directed table,
// then random batches, fill runs and noise, each beat checked against a typed
// table row or a predictor. Depends on fsra_pkg and the design top level only.
`default_nettype none

module tb_fenced_ring_staging_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fsra_pkg::*;

	localparam int unsigned MAX_SEGS    = 16;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_BEATS = 105;
	localparam logic [FENCE_W-1:0] F_MAX = '1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic               act;
		logic [POS_W-1:0]   size;    // capacity for a register row
		logic [FENCE_W-1:0] cmpl;
		logic [FENCE_W-1:0] issued;
		logic               typed;
		status_t            st;
		logic [POS_W-1:0]   off;
		logic [FENCE_W-1:0] wfence;
		logic [FENCE_W-1:0] ffence;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	item_t       item;
	logic        busy;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	// predictor copy of the allocator state
	logic [CAP_W-1:0]   cap_blocks = CAP_RESET;
	logic [POS_W-1:0]   wr_pos     = '0;
	logic [POS_W-1:0]   batch_base = '0;
	logic               batch_live = 1'b0;
	logic               flush_due  = 1'b0;
	logic [POS_W-1:0]   seg_start [MAX_SEGS];
	logic [FENCE_W-1:0] seg_fence [MAX_SEGS];
	logic [3:0]         seg_head   = '0;
	logic [4:0]         seg_count  = '0;

	result_t     grants_due [$];
	int unsigned fails = 0;
	int unsigned burst_left = 0;
	int unsigned stall_cycles = 0;

	row_t plan [23] = '{
		'{ROW_ITEM, ACT_FLUSH, 32'd0, 64'd0, 64'd0, 1'b1, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd0, 64'd0, 64'd0, 1'b1, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd1, 64'd0, 64'd0, 1'b1, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd4096, 64'd0, 64'd0, 1'b1, ST_OK, 32'd4096, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_FLUSH, 32'd0, 64'd0, F_MAX, 1'b1, ST_OK, 32'd0, 64'd0, F_MAX},
		'{ROW_ITEM, ACT_FLUSH, 32'd0, 64'd0, 64'h1234, 1'b1, ST_OK, 32'd0, 64'd0, F_MAX},
		'{ROW_ITEM, ACT_ALLOC, 32'hFFFF_FFFF, 64'd0, 64'd0, 1'b1, ST_EXHAUSTED,
			32'd0, 64'd0, 64'd0},
		'{ROW_CFG, ACT_ALLOC, 32'd1, 64'd0, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd4096, 64'd0, 64'd0, 1'b1, ST_WAITED, 32'd0, F_MAX, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd1, 64'd0, 64'd0, 1'b1, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_FLUSH, 32'd0, 64'd0, 64'd5, 1'b1, ST_OK, 32'd0, 64'd0, 64'd5},
		'{ROW_CFG, ACT_ALLOC, 32'd0, 64'd0, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd0, 64'd0, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd4096, 64'd5, 64'd0, 1'b1, ST_EXHAUSTED,
			32'd0, 64'd0, 64'd0},
		'{ROW_CFG, ACT_ALLOC, 32'hF_FFFF, 64'd0, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'h8000_0000, 64'd0, 64'd0, 1'b1, ST_OK,
			32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'h8000_0001, 64'd0, 64'd0, 1'b1, ST_EXHAUSTED,
			32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_FLUSH, 32'hFFFF_FFFF, 64'd0, 64'd7, 1'b1, ST_OK, 32'd0, 64'd0, 64'd7},
		'{ROW_ITEM, ACT_ALLOC, 32'd4096, F_MAX, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_FLUSH, 32'd0, 64'd0, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_FLUSH, 32'd0, 64'd0, 64'd9, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_ITEM, ACT_ALLOC, 32'd8192, 64'd0, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0},
		'{ROW_CFG, ACT_ALLOC, 32'd4096, 64'd0, 64'd0, 1'b0, ST_OK, 32'd0, 64'd0, 64'd0}
	};

	always #5 clk = ~clk;

	fenced_ring_staging_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	function automatic logic [63:0] ring_span();
		logic [63:0] span;
		span = 64'(cap_blocks) * BLOCK_BYTES;
		return (span > 64'(RING_LIMIT)) ? 64'(RING_LIMIT) : span;
	endfunction

	function automatic void retire_upto(input logic [FENCE_W-1:0] upto);
		while (seg_count != 0 && seg_fence[seg_head] <= upto) begin
			seg_head++;
			seg_count--;
		end
	endfunction

	// work out the grant for one beat and advance the predictor state
	function automatic result_t predict_grant(input item_t it);
		result_t    r;
		logic [63:0] need, room, ring;
		logic       placed;
		logic [3:0] slot;
		r = '{ST_OK, '0, '0, '0};
		if (it.action == ACT_ALLOC) begin
			need = (64'(it.byte_size) + BLOCK_BYTES - 1) / BLOCK_BYTES * BLOCK_BYTES;
			ring = ring_span();
			placed = 1'b0;
			if (!batch_live) begin
				batch_live = 1'b1;
				batch_base = wr_pos;
			end
			for (int try_no = 0; try_no < 2 && !placed; try_no++) begin
				retire_upto(it.completed_fence);
				room = (64'(wr_pos) > ring) ? 64'd0 : ring - 64'(wr_pos);
				if (need <= room) begin
					// the new span covers the oldest segment: wait on its fence
					if (seg_count != 0 && seg_start[seg_head] >= wr_pos &&
					    64'(seg_start[seg_head]) < 64'(wr_pos) + need) begin
						r.status = ST_WAITED;
						r.wait_fence = seg_fence[seg_head];
						retire_upto(r.wait_fence);
					end
					r.offset = wr_pos;
					wr_pos = wr_pos + need[POS_W-1:0];
					flush_due = 1'b1;
					placed = 1'b1;
				end else if (try_no == 0) begin
					wr_pos = '0;
					batch_base = '0;
				end
			end
			if (!placed) begin
				r.status = ST_EXHAUSTED;
				r.offset = '0;
			end
		end else if (!flush_due) begin
			slot = seg_head + seg_count[3:0] - 4'd1;
			if (seg_count != 0) begin
				r.flush_fence = seg_fence[slot];
			end
		end else begin
			batch_live = 1'b0;
			flush_due = 1'b0;
			r.flush_fence = it.issued_fence;
			if (seg_count >= MAX_SEGS) begin
				r.status = ST_OVERFLOW;
			end else begin
				slot = seg_head + seg_count[3:0];
				seg_start[slot] = batch_base;
				seg_fence[slot] = it.issued_fence;
				seg_count++;
			end
		end
		return r;
	endfunction

	function automatic logic [POS_W-1:0] pick_size();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return $urandom;
			2: return $urandom_range(1, BLOCK_BYTES);
			3, 4: return $urandom_range(0, 32'(ring_span() / 3));
			default: return $urandom_range(1, 6) * BLOCK_BYTES - $urandom_range(0, 4095);
		endcase
	endfunction

	// send one beat, with a random gap at the end of each burst
	task automatic issue_beat(input item_t it, input logic typed, input result_t typed_res);
		result_t r;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		r = predict_grant(it);
		grants_due.push_back(typed ? typed_res : r);
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] blocks);
		hold_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= blocks;
		@(posedge clk);
		cap_blocks = blocks;
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (grants_due.size() == 0) begin
				$display("%0t unexpected result beat: got %p", $time, result);
				fails++;
			end else begin
				want = grants_due.pop_front();
				if (result.status !== want.status) begin
					$display("%0t mismatch status: expected %0d, got %0d",
						$time, want.status, result.status);
					fails++;
				end
				if (result.offset !== want.offset) begin
					$display("%0t mismatch offset: expected %0h, got %0h",
						$time, want.offset, result.offset);
					fails++;
				end
				if (result.wait_fence !== want.wait_fence) begin
					$display("%0t mismatch wait_fence: expected %0h, got %0h",
						$time, want.wait_fence, result.wait_fence);
					fails++;
				end
				if (result.flush_fence !== want.flush_fence) begin
					$display("%0t mismatch flush_fence: expected %0h, got %0h",
						$time, want.flush_fence, result.flush_fence);
					fails++;
				end
			end
		end
	end

	// end the run if neither a beat nor a result moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [CAP_W-1:0]   phase_caps [10];
		logic [FENCE_W-1:0] fence_ctr, held_cmpl;
		item_t              it;
		int unsigned        sent;
		phase_caps = '{20'd1, 20'd2, 20'd5, 20'd64, 20'd0, 20'hF_FFFF, 20'd524288,
			20'd4096, 20'd3, 20'd40};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_capacity(plan[i].size[CAP_W-1:0]);
			end else begin
				it = '{plan[i].act, plan[i].size, plan[i].cmpl, plan[i].issued};
				issue_beat(it, plan[i].typed,
					'{plan[i].st, plan[i].off, plan[i].wfence, plan[i].ffence});
			end
		end

		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			fence_ctr = {$urandom, $urandom} >> $urandom_range(8, 63);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				case ($urandom_range(0, 15))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
						// well-formed batch: a few allocations, then the flush
						repeat ($urandom_range(1, 4)) begin
							it = '{ACT_ALLOC, pick_size(),
								fence_ctr - $urandom_range(0, 8), {$urandom, $urandom}};
							issue_beat(it, 1'b0, '{ST_OK, '0, '0, '0});
							sent++;
						end
						fence_ctr += $urandom_range(1, 3);
						it = '{ACT_FLUSH, $urandom, fence_ctr - $urandom_range(0, 8),
							fence_ctr};
						issue_beat(it, 1'b0, '{ST_OK, '0, '0, '0});
						sent++;
					end
					10, 11: begin
						// hold the completed fence so the segment queue fills up
						held_cmpl = fence_ctr;
						repeat ($urandom_range(14, 20)) begin
							it = '{ACT_ALLOC, $urandom_range(1, BLOCK_BYTES), held_cmpl,
								64'd0};
							issue_beat(it, 1'b0, '{ST_OK, '0, '0, '0});
							fence_ctr++;
							it = '{ACT_FLUSH, 32'd0, held_cmpl, fence_ctr};
							issue_beat(it, 1'b0, '{ST_OK, '0, '0, '0});
							sent += 2;
						end
					end
					12, 13, 14: begin
						it = '{1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom},
							{$urandom, $urandom}};
						issue_beat(it, 1'b0, '{ST_OK, '0, '0, '0});
						sent++;
					end
					default: hold_until_drained();
				endcase
			end
		end

		hold_until_drained();
		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/fsra_pkg.sv
design/fsra_seg_mem.sv
design/fsra_cmp.sv
design/fsra_ctrl.sv
design/fenced_ring_staging_allocator_top.sv
design/fsra_checker.sv
tb/sv/tb_fenced_ring_staging_allocator_top.sv
